/* hdl/sbf_pkg.sv */
// shared types and codes for the segment boundary finder
package sbf_pkg;

   localparam int BOUNDARY_WIDTH = 32;

   typedef logic signed [BOUNDARY_WIDTH-1:0] boundary_type;
   typedef logic [1:0] op_type;
   typedef logic [2:0] status_type;

   localparam op_type OP_CLEAR  = 2'd0;
   localparam op_type OP_APPEND = 2'd1;
   localparam op_type OP_QUERY  = 2'd2;

   localparam status_type ST_OK      = 3'd0;
   localparam status_type ST_OVERLAP = 3'd1;
   localparam status_type ST_EMPTY   = 3'd2;
   localparam status_type ST_FULL    = 3'd3;
   localparam status_type ST_ODD     = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic direct_load;   // item finished in the accept cycle
      logic start_search;  // query needs a table search
      logic probe;         // read the midpoint entry
      logic update;        // narrow the search window
      logic adjust;        // pick pair member and read it
      logic finish;        // load the query result
   } sbf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic search_needed;
      logic search_done;
   } sbf_stat_type;

endpackage

/* hdl/sbf_ctrl.sv */
// controller state machine for the segment boundary finder
module sbf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sbf_pkg::sbf_cmd_type cmd,
   input  sbf_pkg::sbf_stat_type stat
);
   import sbf_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PROBE  = 3'd1;
   localparam logic [2:0] S_CMP    = 3'd2;
   localparam logic [2:0] S_ADJUST = 3'd3;
   localparam logic [2:0] S_LOAD   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd              = '0;
      cmd.direct_load  = accept && !stat.search_needed;
      cmd.start_search = accept && stat.search_needed;
      cmd.probe        = (state_ff == S_PROBE);
      cmd.update       = (state_ff == S_CMP);
      cmd.adjust       = (state_ff == S_ADJUST);
      cmd.finish       = (state_ff == S_LOAD) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start_search) state_in = S_PROBE;
         end
         S_PROBE:  state_in = S_CMP;
         S_CMP: begin
            state_in = stat.search_done ? S_ADJUST : S_PROBE;
         end
         S_ADJUST: state_in = S_LOAD;
         S_LOAD: begin
            if (out_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      priority if (cmd.direct_load || cmd.finish) rsp_valid_in = 1'b1;
      else if (rsp_ready)                         rsp_valid_in = 1'b0;
      else                                        rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/sbf_dpath.sv */
// datapath of the segment boundary finder: table memory, search window, result register
module sbf_dpath #(
   parameter int MAX_BOUNDARIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sbf_pkg::sbf_cmd_type  cmd,
   output sbf_pkg::sbf_stat_type stat,
   input  sbf_pkg::op_type       req_operation,
   input  sbf_pkg::boundary_type req_boundary_value,
   input  sbf_pkg::boundary_type req_query_offset,
   input  logic                  req_search_forward,
   input  logic                  req_want_start,
   output logic                  rsp_boundary_found,
   output sbf_pkg::boundary_type rsp_boundary_result,
   output sbf_pkg::status_type   rsp_status
);
   import sbf_pkg::*;

   localparam int CW = $clog2(MAX_BOUNDARIES + 1);
   localparam int AW = $clog2(MAX_BOUNDARIES);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_BOUNDARIES);

   boundary_type bnd_mem [MAX_BOUNDARIES];

   logic [CW-1:0] count_ff, count_in;
   boundary_type  last_ff, last_in;
   boundary_type  rd_data_ff;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff;
   logic [CW-1:0] mid;
   boundary_type  off_ff;
   logic          fwd_ff, ws_ff;
   logic          miss_ff;
   logic          found_ff;
   boundary_type  result_ff;
   status_type    status_ff;

   logic          wr_en;
   status_type    dir_status;
   logic          below;
   logic [CW-1:0] adj_idx;
   logic          adj_miss;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   // queries that need no search: odd or empty table, forward from a negative offset
   assign stat.search_needed = (req_operation == OP_QUERY) && !count_ff[0]
                               && (count_ff != '0)
                               && !(req_search_forward && req_query_offset < 0);

   assign mid   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign below = fwd_ff ? (rd_data_ff <= off_ff) : (rd_data_ff < off_ff);

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.start_search) begin
         lo_in = '0;
         hi_in = count_ff;
      end else if (cmd.update) begin
         if (below) lo_in = mid_ff + 1'b1;
         else       hi_in = mid_ff;
      end
   end

   assign stat.search_done = (lo_in >= hi_in);

   // pick the start or end member of the pair next to the search point
   always_comb begin
      adj_miss = 1'b0;
      if (fwd_ff) begin
         adj_idx = lo_ff;
         if (lo_ff >= count_ff) begin
            adj_miss = 1'b1;
         end else if (ws_ff == lo_ff[0]) begin
            adj_idx = lo_ff + 1'b1;
            if (adj_idx >= count_ff) adj_miss = 1'b1;
         end
      end else begin
         adj_idx = lo_ff - 1'b1;
         if (lo_ff == '0) begin
            adj_miss = 1'b1;
         end else if (ws_ff == adj_idx[0]) begin
            if (adj_idx == '0) adj_miss = 1'b1;
            adj_idx = adj_idx - 1'b1;
         end
      end
   end

   assign rd_en   = cmd.probe || (cmd.adjust && !adj_miss);
   assign rd_addr = cmd.probe ? mid[AW-1:0] : adj_idx[AW-1:0];

   // clear, append and the quick query outcomes
   always_comb begin
      count_in   = count_ff;
      last_in    = last_ff;
      wr_en      = 1'b0;
      dir_status = ST_OK;
      if (cmd.direct_load) begin
         unique case (req_operation)
            OP_CLEAR: begin
               count_in = '0;
            end
            OP_APPEND: begin
               priority if (count_ff == COUNT_MAX) begin
                  dir_status = ST_FULL;
               end else if (!count_ff[0] && count_ff != '0
                            && req_boundary_value < last_ff) begin
                  dir_status = ST_OVERLAP;
               end else if (count_ff[0] && last_ff >= req_boundary_value) begin
                  dir_status = ST_EMPTY;
               end else begin
                  dir_status = ST_OK;
               end
               if (dir_status == ST_OK) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  last_in  = req_boundary_value;
               end
            end
            OP_QUERY: begin
               if (count_ff[0]) dir_status = ST_ODD;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) bnd_mem[count_ff[AW-1:0]] <= req_boundary_value;
      if (rd_en) rd_data_ff <= bnd_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      if (cmd.probe) mid_ff <= mid;
      if (cmd.start_search) begin
         off_ff <= req_query_offset;
         fwd_ff <= req_search_forward;
         ws_ff  <= req_want_start;
      end
      if (cmd.adjust) miss_ff <= adj_miss;
      if (cmd.direct_load) begin
         found_ff  <= 1'b0;
         result_ff <= '0;
         status_ff <= dir_status;
      end else if (cmd.finish) begin
         found_ff  <= !miss_ff;
         result_ff <= miss_ff ? '0 : rd_data_ff;
         status_ff <= ST_OK;
      end
   end

   assign rsp_boundary_found  = found_ff;
   assign rsp_boundary_result = result_ff;
   assign rsp_status          = status_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("boundary count above table size");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff) && count_ff != '0) |-> count_ff == $past(count_ff) + 1'b1)
      else $error("boundary count moved by more than one");

   a_window_open: assert property (@(posedge clock) disable iff (reset)
      (cmd.probe || cmd.update) |-> (lo_ff < hi_ff && hi_ff <= count_ff))
      else $error("search window empty or beyond table");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.finish) |-> rsp_status == ST_OK)
      else $error("search result carries an error status");
`endif

endmodule

/* hdl/segment_boundary_finder_core.sv */
// segment boundary finder: top level joining controller and datapath
//
// Keeps a sorted table of segment boundaries as start/end pairs.
// req_ channel: operation 0 clears the table, 1 appends req_boundary_value,
// 2 queries the next (req_search_forward) or previous start or end
// (req_want_start) boundary relative to req_query_offset.
// rsp_ channel: one transfer per request with found flag, boundary and status.
// Clear, append and queries that need no search (odd or empty table,
// forward from a negative offset) respond the cycle after acceptance.
// A searching query runs a binary search over the table memory: each probe
// is a memory read, then a compare, with at most ceil(log2(count+1)) probes,
// followed by the pair pick and the result load.
// One item is in work at a time.
// The result register lets a new request be taken in the cycle the
// previous result is taken; while the receiver stalls, req_ready stays low
// once a finished result is waiting and no new one can be loaded.
// Reset empties the table (count zero) and drops any pending result.
module segment_boundary_finder_core #(
   parameter int MAX_BOUNDARIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sbf_pkg::op_type       req_operation,
   input  sbf_pkg::boundary_type req_boundary_value,
   input  sbf_pkg::boundary_type req_query_offset,
   input  logic                  req_search_forward,
   input  logic                  req_want_start,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_boundary_found,
   output sbf_pkg::boundary_type rsp_boundary_result,
   output sbf_pkg::status_type   rsp_status
);
   import sbf_pkg::*;

   sbf_cmd_type  cmd;
   sbf_stat_type stat;

   sbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   sbf_dpath #(
      .MAX_BOUNDARIES (MAX_BOUNDARIES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_operation       (req_operation),
      .req_boundary_value  (req_boundary_value),
      .req_query_offset    (req_query_offset),
      .req_search_forward  (req_search_forward),
      .req_want_start      (req_want_start),
      .rsp_boundary_found  (rsp_boundary_found),
      .rsp_boundary_result (rsp_boundary_result),
      .rsp_status          (rsp_status)
   );

endmodule
